@@ hw/rtl/nrcc_pkg.sv @@
// Shared types and constants for the nearest reference color classifier.
// Used by the divider lane, the distance cell and the top level.
package nrcc_pkg;
   localparam int NUM_REFS = 4;
   localparam int REG_REFS = 4;
   localparam logic [2:0] UNKNOWN_CODE = 3'(NUM_REFS);

   localparam int CHAN_W = 16;
   localparam int DIV_W = 24;
   localparam int ACC_W = 34;
   localparam int ROOT_W = 17;
   localparam int REF_W = 48;

   localparam logic [2:0] CSR_INTEG = 3'd0;
   localparam logic [2:0] CSR_LIMIT = 3'd1;
   localparam logic [2:0] CSR_NORM = 3'd2;
   localparam logic [2:0] CSR_REF0 = 3'd3;

   localparam logic [1:0] CH_RED = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE = 2'd2;

   typedef struct packed {
      logic       acc_clr;
      logic       acc_add;
      logic [1:0] sq_sel;
      logic       root_init;
      logic       root_step;
      logic       cmp_en;
   } cell_ctrl_type;

   typedef struct packed {
      logic [ROOT_W-1:0] best;
      logic [2:0]        idx;
   } link_type;
endpackage

@@ hw/rtl/nearest_reference_color_classifier.sv @@
// One item is in work at a time; each passes the bit-serial dividers (a second divide
// pass with normalizing on), the bit-serial roots and the compare chain.
// A held result stalls the next item. A zero divided clear while normalizing ends
// after the first divide pass.
// Synchronous active-high reset clears control and loads register reset values.
// Depends on nrcc_pkg, nrcc_div_lane and nrcc_cell.
module nearest_reference_color_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // red_raw[15:0], green_raw[31:16], blue_raw[47:32], clear_raw[63:48]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // color_index[2:0], match_distance[19:3], divide_error[20], zero[23:21]
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV1 = 3'd1;
   localparam logic [2:0] ST_DCHK = 3'd2;
   localparam logic [2:0] ST_DIV2 = 3'd3;
   localparam logic [2:0] ST_NSAT = 3'd4;
   localparam logic [2:0] ST_SQ   = 3'd5;
   localparam logic [2:0] ST_ROOT = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;
   localparam logic [4:0] DIV_LAST = 5'(nrcc_pkg::DIV_W - 1);
   localparam logic [4:0] SQ_LAST = 5'd3;
   localparam logic [4:0] ROOT_LAST = 5'(nrcc_pkg::ROOT_W);
   localparam logic [4:0] CMP_LAST = 5'(nrcc_pkg::NUM_REFS);

   logic [2:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        cmp_ff, cmp_in;
   logic [8:0]  integ_ff, integ_in;
   logic [16:0] limit_ff, limit_in;
   logic        norm_ff, norm_in;
   logic [nrcc_pkg::CHAN_W-1:0] samp_ff [3];
   logic [nrcc_pkg::CHAN_W-1:0] samp_in [3];
   logic        rvalid_ff, rvalid_in;
   logic [2:0]  ridx_ff, ridx_in;
   logic [16:0] rdist_ff, rdist_in;
   logic        rerr_ff, rerr_in;
   logic [2:0]  pidx_ff, pidx_in;
   logic [16:0] pdist_ff, pdist_in;
   logic        perr_ff, perr_in;

   logic        lane_load, lane_step;
   logic [nrcc_pkg::DIV_W-1:0]  lane_dvd [4];
   logic [nrcc_pkg::DIV_W-1:0]  lane_quo [4];
   logic [nrcc_pkg::CHAN_W-1:0] lane_dsr;
   logic        load_first;
   logic [8:0]  div_eff;
   nrcc_pkg::cell_ctrl_type ctrl;
   nrcc_pkg::link_type      links [nrcc_pkg::NUM_REFS+1];
   logic        req_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc = req_tvalid && req_tready;
   assign div_eff = (integ_ff == 9'd0) ? 9'd1 : integ_ff;
   assign load_first = req_acc;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         lane_dvd[k] = {8'd0, req_tdata[16*k +: 16]};
      end
      lane_dsr = {7'd0, div_eff};
      if (!load_first) begin
         for (int k = 0; k < 3; k++) begin
            lane_dvd[k] = {lane_quo[k][15:0], 8'd0};
         end
         lane_dvd[3] = '0;
         lane_dsr = lane_quo[3][15:0];
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_lane
      nrcc_div_lane u_lane (
         .clock    (clock),
         .load     (lane_load),
         .step     (lane_step),
         .dividend (lane_dvd[k]),
         .divisor  (lane_dsr),
         .quotient (lane_quo[k])
      );
   end

   assign links[0].best = limit_ff;
   assign links[0].idx = nrcc_pkg::UNKNOWN_CODE;

   for (genvar i = 0; i < nrcc_pkg::NUM_REFS; i++) begin : g_cell
      logic ref_we;
      assign ref_we = csr_we && (i < nrcc_pkg::REG_REFS) &&
                      (csr_index == 3'(nrcc_pkg::CSR_REF0 + i));
      nrcc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (3'(i)),
         .ref_we     (ref_we),
         .ref_wdata  (csr_wdata),
         .ctrl       (ctrl),
         .samp_r     (samp_ff[0]),
         .samp_g     (samp_ff[1]),
         .samp_b     (samp_ff[2]),
         .link_left  (links[i]),
         .link_right (links[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff + 5'd1;
      cmp_in = 1'b0;
      lane_load = 1'b0;
      lane_step = 1'b0;
      samp_in = samp_ff;
      pidx_in = pidx_ff;
      pdist_in = pdist_ff;
      perr_in = perr_ff;
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_acc) begin
               lane_load = 1'b1;
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            lane_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_DCHK;
            end
         end
         ST_DCHK: begin
            cnt_in = '0;
            if (norm_ff && lane_quo[3] == '0) begin
               pidx_in = nrcc_pkg::UNKNOWN_CODE;
               pdist_in = limit_ff;
               perr_in = 1'b1;
               state_in = ST_OUT;
            end else if (norm_ff) begin
               lane_load = 1'b1;
               state_in = ST_DIV2;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  samp_in[k] = lane_quo[k][15:0];
               end
               state_in = ST_SQ;
            end
         end
         ST_DIV2: begin
            lane_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_NSAT;
            end
         end
         ST_NSAT: begin
            cnt_in = '0;
            for (int k = 0; k < 3; k++) begin
               samp_in[k] = (lane_quo[k][23:16] != 8'd0) ? 16'hFFFF : lane_quo[k][15:0];
            end
            state_in = ST_SQ;
         end
         ST_SQ: begin
            ctrl.sq_sel = cnt_ff[1:0];
            ctrl.acc_clr = (cnt_ff == 5'd0);
            ctrl.acc_add = (cnt_ff != 5'd0);
            if (cnt_ff == SQ_LAST) begin
               cnt_in = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmp_in = cmp_ff;
            if (!cmp_ff) begin
               ctrl.root_init = (cnt_ff == 5'd0);
               ctrl.root_step = (cnt_ff != 5'd0);
               if (cnt_ff == ROOT_LAST) begin
                  cnt_in = '0;
                  cmp_in = 1'b1;
               end
            end else begin
               ctrl.cmp_en = 1'b1;
               if (cnt_ff == CMP_LAST) begin
                  cmp_in = 1'b0;
                  state_in = ST_OUT;
                  pidx_in = links[nrcc_pkg::NUM_REFS].idx;
                  pdist_in = links[nrcc_pkg::NUM_REFS].best;
                  perr_in = 1'b0;
               end
            end
         end
         ST_OUT: begin
            cnt_in = '0;
            if (cmp_ff) begin
               cmp_in = 1'b0;
            end
            if (!rvalid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rvalid_in = rvalid_ff;
      ridx_in = ridx_ff;
      rdist_in = rdist_ff;
      rerr_in = rerr_ff;
      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end
      if (state_ff == ST_OUT && (!rvalid_ff || rsp_tready)) begin
         rvalid_in = 1'b1;
         ridx_in = pidx_ff;
         rdist_in = pdist_ff;
         rerr_in = perr_ff;
      end
      integ_in = integ_ff;
      limit_in = limit_ff;
      norm_in = norm_ff;
      if (csr_we) begin
         unique case (csr_index)
            nrcc_pkg::CSR_INTEG: integ_in = csr_wdata[8:0];
            nrcc_pkg::CSR_LIMIT: limit_in = csr_wdata[16:0];
            nrcc_pkg::CSR_NORM:  norm_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         cmp_ff <= 1'b0;
         rvalid_ff <= 1'b0;
         integ_ff <= 9'd1;
         limit_ff <= 17'd20;
         norm_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         cmp_ff <= cmp_in;
         rvalid_ff <= rvalid_in;
         integ_ff <= integ_in;
         limit_ff <= limit_in;
         norm_ff <= norm_in;
      end
      samp_ff <= samp_in;
      pidx_ff <= pidx_in;
      pdist_ff <= pdist_in;
      perr_ff <= perr_in;
      ridx_ff <= ridx_in;
      rdist_ff <= rdist_in;
      rerr_ff <= rerr_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata = {3'd0, rerr_ff, rdist_ff, ridx_ff};

   a_err_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rerr_ff |-> ridx_ff == nrcc_pkg::UNKNOWN_CODE)
      else $error("divide error without unknown index");
   a_match_below: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ridx_ff != nrcc_pkg::UNKNOWN_CODE |-> rdist_ff < limit_ff)
      else $error("match distance not below limit");
   a_nomatch_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ridx_ff == nrcc_pkg::UNKNOWN_CODE |-> rdist_ff == limit_ff)
      else $error("unknown result without limit distance");
   a_accept_div: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_DIV1 && cnt_ff == 5'd0)
      else $error("accepted item did not start division");
endmodule

@@ hw/rtl/nrcc_div_lane.sv @@
// Restoring divider lane, one quotient bit per cycle while step is high.
// Depends on nrcc_pkg for widths.
module nrcc_div_lane (
   input  logic                         clock,
   input  logic                         load,
   input  logic                         step,
   input  logic [nrcc_pkg::DIV_W-1:0]   dividend,
   input  logic [nrcc_pkg::CHAN_W-1:0]  divisor,
   output logic [nrcc_pkg::DIV_W-1:0]   quotient
);
   logic [nrcc_pkg::CHAN_W-1:0] rem_ff, rem_in;
   logic [nrcc_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [nrcc_pkg::CHAN_W-1:0] dsr_ff, dsr_in;
   logic [nrcc_pkg::CHAN_W:0]   rem_sh;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      rem_sh = {rem_ff, quo_ff[nrcc_pkg::DIV_W-1]};
      if (load) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
      end else if (step) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = nrcc_pkg::CHAN_W'(rem_sh - {1'b0, dsr_ff});
            quo_in = {quo_ff[nrcc_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[nrcc_pkg::CHAN_W-1:0];
            quo_in = {quo_ff[nrcc_pkg::DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
endmodule

@@ hw/rtl/nrcc_cell.sv @@
// Distance cell: holds one reference color, forms the squared distance,
// takes its bit-serial root and passes the running best to its neighbor.
// Depends on nrcc_pkg.
module nrcc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [2:0]                    cell_idx,
   input  logic                          ref_we,
   input  logic [nrcc_pkg::REF_W-1:0]    ref_wdata,
   input  nrcc_pkg::cell_ctrl_type       ctrl,
   input  logic [nrcc_pkg::CHAN_W-1:0]   samp_r,
   input  logic [nrcc_pkg::CHAN_W-1:0]   samp_g,
   input  logic [nrcc_pkg::CHAN_W-1:0]   samp_b,
   input  nrcc_pkg::link_type            link_left,
   output nrcc_pkg::link_type            link_right
);
   logic [nrcc_pkg::REF_W-1:0]    ref_ff, ref_in;
   logic [2*nrcc_pkg::CHAN_W-1:0] sq_ff, sq_in;
   logic [nrcc_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [nrcc_pkg::ACC_W-1:0]    v_ff, v_in;
   logic [nrcc_pkg::ROOT_W+1:0]   rem_ff, rem_in;
   logic [nrcc_pkg::ROOT_W-1:0]   root_ff, root_in;
   nrcc_pkg::link_type            link_ff, link_in;
   logic [nrcc_pkg::CHAN_W-1:0]   s_chan, r_chan, diff;
   logic [nrcc_pkg::ROOT_W+3:0]   rem_sh, trial;

   always_comb begin
      case (ctrl.sq_sel)
         nrcc_pkg::CH_RED: begin
            s_chan = samp_r;
            r_chan = ref_ff[47:32];
         end
         nrcc_pkg::CH_GREEN: begin
            s_chan = samp_g;
            r_chan = ref_ff[31:16];
         end
         nrcc_pkg::CH_BLUE: begin
            s_chan = samp_b;
            r_chan = ref_ff[15:0];
         end
         default: begin
            s_chan = '0;
            r_chan = '0;
         end
      endcase
      diff = (s_chan >= r_chan) ? s_chan - r_chan : r_chan - s_chan;
      sq_in = diff * diff;

      ref_in = ref_we ? ref_wdata : ref_ff;

      acc_in = acc_ff;
      if (ctrl.acc_clr) begin
         acc_in = '0;
      end else if (ctrl.acc_add) begin
         acc_in = acc_ff + nrcc_pkg::ACC_W'(sq_ff);
      end

      v_in = v_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      rem_sh = {rem_ff, v_ff[nrcc_pkg::ACC_W-1:nrcc_pkg::ACC_W-2]};
      trial = {2'b00, root_ff, 2'b01};
      if (ctrl.root_init) begin
         v_in = acc_ff;
         rem_in = '0;
         root_in = '0;
      end else if (ctrl.root_step) begin
         v_in = {v_ff[nrcc_pkg::ACC_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in = (nrcc_pkg::ROOT_W+2)'(rem_sh - trial);
            root_in = {root_ff[nrcc_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[nrcc_pkg::ROOT_W+1:0];
            root_in = {root_ff[nrcc_pkg::ROOT_W-2:0], 1'b0};
         end
      end

      link_in = link_ff;
      if (ctrl.cmp_en) begin
         if (root_ff < link_left.best) begin
            link_in.best = root_ff;
            link_in.idx = cell_idx;
         end else begin
            link_in = link_left;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= '0;
      end else begin
         ref_ff <= ref_in;
      end
      sq_ff <= sq_in;
      acc_ff <= acc_in;
      v_ff <= v_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      link_ff <= link_in;
   end

   assign link_right = link_ff;
endmodule
